// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define BDA_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bda assertion failed");

// Same-cycle implication, built on the clocked form.
`define BDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    `BDA_ASSERT_RST(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// ===== rtl/core/bda_pkg.sv =====
package bda_pkg;

    // Default operand length in decimal digits
    localparam int unsigned DIGITS_DEF = 16;
    // Fixed width of the operand and result fields
    localparam int unsigned DATA_W = 64;

    // Operation codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    // Input transaction
    typedef struct packed {
        logic [2:0]        operation;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } t_in;

    // Output transaction
    typedef struct packed {
        logic [DATA_W-1:0] result_digits;
        logic              a_equal_b;
        logic              a_greater_b;
        logic              a_less_b;
        logic              divide_by_zero;
    } t_out;

    // Commands from the top level to the sequencer
    typedef struct packed {
        logic start;
        logic take;
    } t_seq_cmd;

    // Sequencer status
    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_sts;

endpackage

// ===== rtl/core/decimal_bcd_alu.sv =====
// Decimal BCD arithmetic unit: add, subtract, multiply, divide or compare two
// unsigned packed-BCD operands of DIGITS digits; nibbles above 9 read as 0 and
// results wrap modulo 10^DIGITS. One transaction is in work at a time; o_in_ready
// is low from acceptance until the result moves into the output register, which
// then waits for the consumer while the next transaction is taken. Compare, spare
// codes and divide by zero go straight to done; add and subtract make one pass
// through the adder; multiply adds the multiplicand once per unit of each
// multiplier digit; divide makes trial subtracts until one borrows, per quotient
// digit. o_in_ready rises the cycle after the result moves out. All arithmetic
// uses the single word-wide BCD adder/subtractor, which does one add or trial
// subtract per cycle.
module decimal_bcd_alu import bda_pkg::*; #(
    parameter int unsigned DIGITS = DIGITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int unsigned W = 4 * DIGITS;

    logic [W-1:0] san_a;
    logic [W-1:0] san_b;
    logic         in_fire;
    logic         div_zero;
    logic [2:0]   eff_op;
    t_seq_cmd     seq_cmd;
    t_seq_sts     seq_sts;
    logic [W-1:0] seq_result;

    logic         r_eq, r_gt, r_lt, r_dz;
    logic         r_out_valid;
    t_out         r_out_data;

    // Clean operands: invalid nibbles to zero, unused digits dropped
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            san_a[4*k +: 4] = (i_in_data.operand_a[4*k +: 4] > 4'd9)
                              ? 4'd0 : i_in_data.operand_a[4*k +: 4];
            san_b[4*k +: 4] = (i_in_data.operand_b[4*k +: 4] > 4'd9)
                              ? 4'd0 : i_in_data.operand_b[4*k +: 4];
        end
    end

    assign in_fire  = i_in_valid && o_in_ready;
    assign div_zero = (i_in_data.operation == OP_DIV) && (san_b == '0);
    // A zero divisor skips the division loop
    assign eff_op   = div_zero ? OP_CMP : i_in_data.operation;

    assign o_in_ready    = seq_sts.idle;
    assign seq_cmd.start = in_fire;
    assign seq_cmd.take  = seq_sts.done && (!r_out_valid || i_out_ready);

    bda_seq #(.DIGITS(DIGITS)) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (seq_cmd),
        .i_op     (eff_op),
        .i_a      (san_a),
        .i_b      (san_b),
        .o_sts    (seq_sts),
        .o_result (seq_result)
    );

    // Flags at acceptance; packed BCD orders like binary
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_eq <= (san_a == san_b);
            r_gt <= (san_a > san_b);
            r_lt <= (san_a < san_b);
            r_dz <= div_zero;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_cmd.take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (seq_cmd.take) begin
            r_out_data.result_digits  <= DATA_W'(seq_result);
            r_out_data.a_equal_b      <= r_eq;
            r_out_data.a_greater_b    <= r_gt;
            r_out_data.a_less_b       <= r_lt;
            r_out_data.divide_by_zero <= r_dz;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/core/bda_addsub.sv =====
// Word-wide BCD adder/subtractor: x + y, or x - y by nines complement plus one.
// Uses the excess-six trick: add 6 to every digit, add in binary, then take
// 6 back from each digit that produced no decimal carry.
module bda_addsub import bda_pkg::*; #(
    parameter int unsigned ND = DIGITS_DEF + 1
) (
    input  logic [4*ND-1:0] i_x,
    input  logic [4*ND-1:0] i_y,
    input  logic            i_sub,
    output logic [4*ND-1:0] o_sum,
    output logic            o_carry
);

    localparam int unsigned WX = 4 * ND;
    localparam logic [WX-1:0] SIX = {ND{4'h6}};

    logic [WX-1:0] yy;
    logic [WX-1:0] t1;
    logic [WX:0]   t2;
    logic [WX:0]   cvec;

    // Nines complement of y for subtract
    always_comb begin
        for (int k = 0; k < ND; k++) begin
            yy[4*k +: 4] = i_sub ? (4'd9 - i_y[4*k +: 4]) : i_y[4*k +: 4];
        end
    end

    // Biased binary add; carry-ins per bit recovered by xor
    assign t1   = i_x + SIX;
    assign t2   = {1'b0, t1} + {1'b0, yy} + (WX+1)'(i_sub);
    assign cvec = {t2[WX], t2[WX-1:0] ^ t1 ^ yy};

    // Remove the bias from digits without a decimal carry out
    always_comb begin
        for (int k = 0; k < ND; k++) begin
            o_sum[4*k +: 4] = t2[4*k +: 4] - (cvec[4*k+4] ? 4'd0 : 4'd6);
        end
    end

    assign o_carry = t2[WX];

endmodule

// ===== rtl/core/bda_seq.sv =====
// Sequencer for the decimal operations around one shared BCD add/subtract unit.
// Multiply: shift-and-add one multiplier digit at a time.
// Divide: restoring long division, one quotient digit at a time.
module bda_seq import bda_pkg::*; #(
    parameter int unsigned DIGITS = DIGITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_seq_cmd              i_cmd,
    input  logic [2:0]            i_op,
    input  logic [4*DIGITS-1:0]   i_a,
    input  logic [4*DIGITS-1:0]   i_b,
    output t_seq_sts              o_sts,
    output logic [4*DIGITS-1:0]   o_result
);

    localparam int unsigned W  = 4 * DIGITS;
    localparam int unsigned WX = W + 4;
    localparam int unsigned DW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [DW-1:0] DIG_LAST = DW'(DIGITS - 1);
    localparam logic [WX-1:0] LOW_MASK = {4'h0, {W{1'b1}}};

    // State codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADDSUB = 3'd1;
    localparam logic [2:0] S_MSHIFT = 3'd2;
    localparam logic [2:0] S_MADD   = 3'd3;
    localparam logic [2:0] S_DSHIFT = 3'd4;
    localparam logic [2:0] S_DSUB   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_op,    n_op;
    logic [W-1:0]  r_a,     n_a;
    logic [W-1:0]  r_b,     n_b;
    logic [WX-1:0] r_acc,   n_acc;
    logic [W-1:0]  r_quo,   n_quo;
    logic [DW-1:0] r_dig,   n_dig;
    logic [3:0]    r_cnt,   n_cnt;

    logic [WX-1:0] u_x;
    logic [WX-1:0] u_y;
    logic          u_sub;
    logic [WX-1:0] u_sum;
    logic          u_carry;

    // Shared arithmetic unit, one digit wider than the operands
    bda_addsub #(.ND(DIGITS + 1)) u_addsub (
        .i_x     (u_x),
        .i_y     (u_y),
        .i_sub   (u_sub),
        .o_sum   (u_sum),
        .o_carry (u_carry)
    );

    // Unit operand selection
    always_comb begin
        u_x   = r_acc;
        u_y   = {4'h0, r_b};
        u_sub = 1'b0;
        unique case (r_state)
            S_ADDSUB: begin
                u_x   = {4'h0, r_a};
                u_sub = (r_op == OP_SUB);
            end
            S_MADD: begin
                u_y = {4'h0, r_a};
            end
            S_DSUB: begin
                u_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Next-state and datapath logic
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_quo   = r_quo;
        n_dig   = r_dig;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_op  = i_op;
                    n_a   = i_a;
                    n_b   = i_b;
                    n_acc = '0;
                    n_quo = '0;
                    n_dig = DIG_LAST;
                    n_cnt = '0;
                    unique case (i_op) inside
                        OP_ADD, OP_SUB: n_state = S_ADDSUB;
                        OP_MUL:         n_state = S_MSHIFT;
                        OP_DIV:         n_state = S_DSHIFT;
                        default:        n_state = S_DONE;
                    endcase
                end
            end
            S_ADDSUB: begin
                n_acc   = u_sum & LOW_MASK;
                n_state = S_DONE;
            end
            // Next multiplier digit: shift the partial product one digit up
            S_MSHIFT: begin
                n_cnt   = r_b[W-1 -: 4];
                n_b     = r_b << 4;
                n_acc   = (r_acc << 4) & LOW_MASK;
                n_state = S_MADD;
            end
            // Add the multiplicand once per unit of the current digit
            S_MADD: begin
                if (r_cnt != 4'd0) begin
                    n_acc = u_sum & LOW_MASK;
                    n_cnt = r_cnt - 4'd1;
                end else if (r_dig == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_dig   = r_dig - DW'(1);
                    n_state = S_MSHIFT;
                end
            end
            // Bring down the next dividend digit
            S_DSHIFT: begin
                n_acc   = (r_acc << 4) | WX'(r_a[W-1 -: 4]);
                n_a     = r_a << 4;
                n_cnt   = '0;
                n_state = S_DSUB;
            end
            // Trial subtract; a borrow ends the digit
            S_DSUB: begin
                if (u_carry) begin
                    n_acc = u_sum;
                    n_cnt = r_cnt + 4'd1;
                end else begin
                    n_quo = (r_quo << 4) | W'(r_cnt);
                    if (r_dig == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_dig   = r_dig - DW'(1);
                        n_state = S_DSHIFT;
                    end
                end
            end
            S_DONE: begin
                if (i_cmd.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dig   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_dig   <= n_dig;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_quo <= n_quo;
    end

    // Result selection
    always_comb begin
        case (r_op) inside
            OP_ADD, OP_SUB, OP_MUL: o_result = r_acc[W-1:0];
            OP_DIV:                 o_result = r_quo;
            default:                o_result = '0;
        endcase
    end

    assign o_sts.idle = (r_state == S_IDLE);
    assign o_sts.done = (r_state == S_DONE);

endmodule

// ===== rtl/core/bda_checker.sv =====
`include "assert_macros.svh"

// Port-level checks on the decimal BCD unit
module bda_checker import bda_pkg::*; #(
    parameter int unsigned DIGITS = DIGITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    logic       bcd_ok;
    logic       in_acc;
    logic       out_stall;
    logic [2:0] flags;

    // Result digits are decimal, unused digits are zero
    always_comb begin
        bcd_ok = 1'b1;
        for (int k = 0; k < DATA_W / 4; k++) begin
            if (k < DIGITS) begin
                if (o_out_data.result_digits[4*k +: 4] > 4'd9) begin
                    bcd_ok = 1'b0;
                end
            end else if (o_out_data.result_digits[4*k +: 4] != 4'd0) begin
                bcd_ok = 1'b0;
            end
        end
    end

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign flags     = {o_out_data.a_equal_b, o_out_data.a_greater_b, o_out_data.a_less_b};

    // A transaction in work blocks the next one
    `BDA_ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> !o_in_ready)

    `BDA_ASSERT_IMP(a_flags_onehot, i_clk, i_rst_n, o_out_valid, $onehot(flags))

    `BDA_ASSERT_IMP(a_dz_zero_result, i_clk, i_rst_n, o_out_valid && o_out_data.divide_by_zero, o_out_data.result_digits == '0)

    `BDA_ASSERT_IMP(a_result_bcd, i_clk, i_rst_n, o_out_valid, bcd_ok)

    // A waiting result holds until taken
    `BDA_ASSERT_RST(a_out_hold, i_clk, i_rst_n, out_stall |=> (o_out_valid && $stable(o_out_data)))

endmodule

bind decimal_bcd_alu bda_checker #(.DIGITS(DIGITS)) u_bda_checker (.*);
